/* rtl/rwd_pkg.sv */
// ----------------------------------------------------------------------------
// rwd_pkg
// shared constants, register indexes and modular add helper
// ----------------------------------------------------------------------------
package rwd_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int MAX_W           = 64;
    localparam int BYTE_W          = 8;
    localparam int INDEX_W         = 2;

    typedef enum logic [INDEX_W-1:0] {
        REG_MODULUS  = 2'd0,
        REG_EXPONENT = 2'd1
    } reg_index_t;

    // (x + y) mod m for x, y below m
    function automatic logic [MAX_W-1:0] add_mod(
        input logic [MAX_W-1:0] x,
        input logic [MAX_W-1:0] y,
        input logic [MAX_W-1:0] m
    );
        logic [MAX_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[MAX_W-1:0];
    endfunction

endpackage

/* rtl/rwd_in_if.sv */
// ----------------------------------------------------------------------------
// rwd_in_if
// ciphertext channel: valid/ready with word and last flag
// ----------------------------------------------------------------------------
interface rwd_in_if #(
    parameter int W = rwd_pkg::VALUE_WIDTH_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] cipher_word;
    logic         last_word;

    modport source (output valid, output cipher_word, output last_word, input ready);
    modport sink   (input valid, input cipher_word, input last_word, output ready);
endinterface

/* rtl/rwd_out_if.sv */
// ----------------------------------------------------------------------------
// rwd_out_if
// plaintext channel: valid/ready with byte, residue and last flag
// ----------------------------------------------------------------------------
interface rwd_out_if #(
    parameter int W = rwd_pkg::VALUE_WIDTH_DEF
);
    logic                       valid;
    logic                       ready;
    logic [rwd_pkg::BYTE_W-1:0] plain_byte;
    logic [W-1:0]               residue;
    logic                       last_out;

    modport source (output valid, output plain_byte, output residue, output last_out,
                    input ready);
    modport sink   (input valid, input plain_byte, input residue, input last_out,
                    output ready);
endinterface

/* rtl/rwd_reduce.sv */
// ----------------------------------------------------------------------------
// rwd_reduce
// word mod modulus, one restoring step per stage, msb first
// ----------------------------------------------------------------------------
module rwd_reduce #(
    parameter int W = rwd_pkg::VALUE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] m,
    input  logic         in_valid,
    input  logic [W-1:0] in_word,
    input  logic         in_last,
    output logic         out_valid,
    output logic [W-1:0] out_base,
    output logic         out_last
);

    logic         valid_reg [W];
    logic [W-1:0] rem_reg   [W];
    logic [W-1:0] word_reg  [W];
    logic         last_reg  [W];

    for (genvar s = 0; s < W; s++)
    begin : g_stage
        logic         v_in;
        logic [W-1:0] r_in;
        logic [W-1:0] w_in;
        logic         l_in;
        logic [W:0]   shifted;
        logic [W-1:0] rem_next;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign w_in = in_word;
            assign l_in = in_last;
        end
        else
        begin : g_rest
            assign v_in = valid_reg[s-1];
            assign r_in = rem_reg[s-1];
            assign w_in = word_reg[s-1];
            assign l_in = last_reg[s-1];
        end

        always_comb
        begin
            shifted = {r_in, w_in[W-1-s]};
            if (shifted >= {1'b0, m})
            begin
                shifted = shifted - {1'b0, m};
            end
            rem_next = shifted[W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                word_reg[s] <= w_in;
                last_reg[s] <= l_in;
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign out_base  = rem_reg[W-1];
    assign out_last  = last_reg[W-1];

endmodule

/* rtl/rwd_exp_bit.sv */
// ----------------------------------------------------------------------------
// rwd_exp_bit
// one exponent bit: acc*base and base*base by shift and add, one bit a stage
// ----------------------------------------------------------------------------
module rwd_exp_bit #(
    parameter int W = rwd_pkg::VALUE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] m,
    input  logic         exp_bit,
    input  logic         in_valid,
    input  logic [W-1:0] in_acc,
    input  logic [W-1:0] in_base,
    input  logic         in_last,
    output logic         out_valid,
    output logic [W-1:0] out_acc,
    output logic [W-1:0] out_base,
    output logic         out_last
);

    logic         valid_reg [W];
    logic [W-1:0] acc_reg   [W];
    logic [W-1:0] base_reg  [W];
    logic [W-1:0] x1_reg    [W];
    logic [W-1:0] x2_reg    [W];
    logic [W-1:0] r1_reg    [W];
    logic [W-1:0] r2_reg    [W];
    logic         last_reg  [W];

    for (genvar s = 0; s < W; s++)
    begin : g_stage
        logic         v_in;
        logic [W-1:0] a_in;
        logic [W-1:0] b_in;
        logic [W-1:0] x1_in;
        logic [W-1:0] x2_in;
        logic [W-1:0] r1_in;
        logic [W-1:0] r2_in;
        logic         l_in;
        logic [W-1:0] x1_next;
        logic [W-1:0] x2_next;
        logic [W-1:0] r1_next;
        logic [W-1:0] r2_next;

        if (s == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign a_in  = in_acc;
            assign b_in  = in_base;
            assign x1_in = in_acc;
            assign x2_in = in_base;
            assign r1_in = '0;
            assign r2_in = '0;
            assign l_in  = in_last;
        end
        else
        begin : g_rest
            assign v_in  = valid_reg[s-1];
            assign a_in  = acc_reg[s-1];
            assign b_in  = base_reg[s-1];
            assign x1_in = x1_reg[s-1];
            assign x2_in = x2_reg[s-1];
            assign r1_in = r1_reg[s-1];
            assign r2_in = r2_reg[s-1];
            assign l_in  = last_reg[s-1];
        end

        always_comb
        begin
            x1_next = W'(rwd_pkg::add_mod(rwd_pkg::MAX_W'(x1_in), rwd_pkg::MAX_W'(x1_in),
                                          rwd_pkg::MAX_W'(m)));
            x2_next = W'(rwd_pkg::add_mod(rwd_pkg::MAX_W'(x2_in), rwd_pkg::MAX_W'(x2_in),
                                          rwd_pkg::MAX_W'(m)));
            r1_next = r1_in;
            r2_next = r2_in;
            if (b_in[s])
            begin
                r1_next = W'(rwd_pkg::add_mod(rwd_pkg::MAX_W'(r1_in), rwd_pkg::MAX_W'(x1_in),
                                              rwd_pkg::MAX_W'(m)));
                r2_next = W'(rwd_pkg::add_mod(rwd_pkg::MAX_W'(r2_in), rwd_pkg::MAX_W'(x2_in),
                                              rwd_pkg::MAX_W'(m)));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s]  <= a_in;
                base_reg[s] <= b_in;
                x1_reg[s]   <= x1_next;
                x2_reg[s]   <= x2_next;
                r1_reg[s]   <= r1_next;
                r2_reg[s]   <= r2_next;
                last_reg[s] <= l_in;
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign out_acc   = exp_bit ? r1_reg[W-1] : acc_reg[W-1];
    assign out_base  = r2_reg[W-1];
    assign out_last  = last_reg[W-1];

endmodule

/* rtl/rsa_word_decrypt.sv */
// throughput: one word per cycle while the output is not stalled; every modular step has its own stage
// the word reduction uses W stages, each exponent bit W shift-and-add stages
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// reset: modulus 2, exponent 0, all stage valid bits cleared
// ----------------------------------------------------------------------------
// rsa_word_decrypt
// pipelined square-and-multiply modular exponentiation of one word per item
// ----------------------------------------------------------------------------
module rsa_word_decrypt #(
    parameter int VALUE_WIDTH = rwd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        write_enable,
    input  logic [rwd_pkg::INDEX_W-1:0] reg_index,
    input  logic [VALUE_WIDTH-1:0]      write_data,
    rwd_in_if.sink                      cipher,
    rwd_out_if.source                   plain
);

    localparam int W = VALUE_WIDTH;

    logic [W-1:0] modulus_reg;
    logic [W-1:0] exponent_reg;
    logic         en;

    logic         red_valid;
    logic [W-1:0] red_base;
    logic         red_last;

    logic         e_valid [W+1];
    logic [W-1:0] e_acc   [W+1];
    logic [W-1:0] e_base  [W+1];
    logic         e_last  [W+1];

    logic                       out_valid_reg;
    logic [rwd_pkg::BYTE_W-1:0] byte_reg;
    logic [W-1:0]               residue_reg;
    logic                       last_reg;
    logic [W-1:0]               residue_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= W'(2);
            exponent_reg <= '0;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                rwd_pkg::REG_MODULUS:  modulus_reg  <= write_data;
                rwd_pkg::REG_EXPONENT: exponent_reg <= write_data;
                default:               ;
            endcase
        end
    end

    assign en           = !out_valid_reg || plain.ready;
    assign cipher.ready = en;

    rwd_reduce #(.W(W)) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .m         (modulus_reg),
        .in_valid  (cipher.valid),
        .in_word   (cipher.cipher_word),
        .in_last   (cipher.last_word),
        .out_valid (red_valid),
        .out_base  (red_base),
        .out_last  (red_last)
    );

    assign e_valid[0] = red_valid;
    assign e_acc[0]   = W'(1);
    assign e_base[0]  = red_base;
    assign e_last[0]  = red_last;

    for (genvar k = 0; k < W; k++)
    begin : g_bit
        rwd_exp_bit #(.W(W)) u_exp_bit (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .m         (modulus_reg),
            .exp_bit   (exponent_reg[k]),
            .in_valid  (e_valid[k]),
            .in_acc    (e_acc[k]),
            .in_base   (e_base[k]),
            .in_last   (e_last[k]),
            .out_valid (e_valid[k+1]),
            .out_acc   (e_acc[k+1]),
            .out_base  (e_base[k+1]),
            .out_last  (e_last[k+1])
        );
    end

    // no residue exists below a modulus of two
    assign residue_next = (modulus_reg[W-1:1] == '0) ? '0 : e_acc[W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= e_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            residue_reg <= residue_next;
            byte_reg    <= rwd_pkg::BYTE_W'(residue_next);
            last_reg    <= e_last[W];
        end
    end

    assign plain.valid      = out_valid_reg;
    assign plain.plain_byte = byte_reg;
    assign plain.residue    = residue_reg;
    assign plain.last_out   = last_reg;

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        plain.valid && !plain.ready |=> plain.valid && $stable(plain.residue)
                                        && $stable(plain.last_out))
        else $error("waiting result changed before its transfer");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        plain.valid && !plain.ready |-> !cipher.ready)
        else $error("input accepted while the output is stalled");

    a_byte_matches : assert property (@(posedge clk) disable iff (!rst_n)
        plain.valid |-> plain.plain_byte == plain.residue[rwd_pkg::BYTE_W-1:0])
        else $error("plaintext byte differs from residue low bits");

endmodule
